FILE: rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Widths, pipeline payload types and helpers shared by the segment
// intersection pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

    // coordinate format: signed Q11.4
    localparam int COORD_BITS = 16;
    localparam int NUM_COORDS = 8;

    // intermediate widths, all exact
    localparam int DIFF_W  = COORD_BITS + 1;        // endpoint differences
    localparam int PROD_W  = 2 * COORD_BITS;        // coordinate products
    localparam int CROSS_W = PROD_W + 1;            // segment cross terms
    localparam int DPRD_W  = 2 * DIFF_W;            // denominator products
    localparam int DEN_W   = DPRD_W + 1;            // denominator
    localparam int NPRD_W  = CROSS_W + DIFF_W;      // numerator products
    localparam int NUM_W   = NPRD_W + 1;            // numerators

    // quotient magnitude bits; the top one flags overflow
    localparam int QUOT_W  = COORD_BITS + 2;
    localparam int SHDIV_W = DEN_W + QUOT_W - 1;    // divisor at top alignment

    // saturation limits of the coordinate range
    localparam logic [QUOT_W-1:0] QMAX_POS = QUOT_W'((1 << (COORD_BITS - 1)) - 1);
    localparam logic [QUOT_W-1:0] QMAX_NEG = QUOT_W'(1 << (COORD_BITS - 1));
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // coordinate order: x1 y1 x2 y2 x3 y3 x4 y4
    localparam int IDX_X1 = 0;
    localparam int IDX_Y1 = 1;
    localparam int IDX_X2 = 2;
    localparam int IDX_Y2 = 3;
    localparam int IDX_X3 = 4;
    localparam int IDX_Y3 = 5;
    localparam int IDX_X4 = 6;
    localparam int IDX_Y4 = 7;

    typedef logic [NUM_COORDS-1:0][COORD_BITS-1:0] t_coords;

    // payload through the divider stages
    typedef struct packed {
        logic                parallel;
        logic                neg_x;
        logic                neg_y;
        logic [SHDIV_W-1:0]  divisor;
        logic [NUM_W-1:0]    rem_x;
        logic [NUM_W-1:0]    rem_y;
        logic [QUOT_W-1:0]   quot_x;
        logic [QUOT_W-1:0]   quot_y;
        t_coords             coords;
    } t_div;

    // stream widths
    localparam int IN_DATA_W  = NUM_COORDS * COORD_BITS;
    localparam int OUT_BITS   = 2 + 2 * COORD_BITS;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

FILE: rtl/sip_front.sv
// ----------------------------------------------------------------------------
// sip_front
// Five registered stages forming the exact denominator and numerators, then
// their signs and magnitudes, ready for the divider.
// ----------------------------------------------------------------------------
module sip_front import sip_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_coords i_coords,
    output logic    o_valid,
    output t_div    o_div
);

    // stage valids
    logic [4:0] r_valid;

    // stage 1: differences and coordinate products
    logic signed [DIFF_W-1:0]  r_dx12, r_dy12, r_dx34, r_dy34;
    logic signed [PROD_W-1:0]  r_p_x1y2, r_p_y1x2, r_p_x3y4, r_p_y3x4;
    t_coords                   r_c1;

    // stage 2: cross terms and denominator products
    logic signed [CROSS_W-1:0] r_c12, r_c34;
    logic signed [DPRD_W-1:0]  r_da, r_db;
    logic signed [DIFF_W-1:0]  r2_dx12, r2_dy12, r2_dx34, r2_dy34;
    t_coords                   r_c2;

    // stage 3: denominator and numerator products
    logic signed [DEN_W-1:0]   r_den3;
    logic signed [NPRD_W-1:0]  r_na, r_nb, r_nc, r_nd;
    t_coords                   r_c3;

    // stage 4: numerators
    logic signed [DEN_W-1:0]   r_den4;
    logic signed [NUM_W-1:0]   r_nx, r_ny;
    t_coords                   r_c4;

    // stage 5: signs and magnitudes
    t_div                      r_div;

    logic signed [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [DIFF_W-1:0]  n_dx12, n_dy12, n_dx34, n_dy34;
    logic signed [PROD_W-1:0]  n_p_x1y2, n_p_y1x2, n_p_x3y4, n_p_y3x4;
    logic signed [CROSS_W-1:0] n_c12, n_c34;
    logic signed [DPRD_W-1:0]  n_da, n_db;
    logic signed [DEN_W-1:0]   n_den3;
    logic signed [NPRD_W-1:0]  n_na, n_nb, n_nc, n_nd;
    logic signed [NUM_W-1:0]   n_nx, n_ny;
    logic [NUM_W-1:0]          mag_x, mag_y;
    logic [DEN_W-1:0]          mag_d;
    t_div                      n_div;

    assign x1 = i_coords[IDX_X1];
    assign y1 = i_coords[IDX_Y1];
    assign x2 = i_coords[IDX_X2];
    assign y2 = i_coords[IDX_Y2];
    assign x3 = i_coords[IDX_X3];
    assign y3 = i_coords[IDX_Y3];
    assign x4 = i_coords[IDX_X4];
    assign y4 = i_coords[IDX_Y4];

    // stage 1 logic
    always_comb begin
        n_dx12   = DIFF_W'(x1) - DIFF_W'(x2);
        n_dy12   = DIFF_W'(y1) - DIFF_W'(y2);
        n_dx34   = DIFF_W'(x3) - DIFF_W'(x4);
        n_dy34   = DIFF_W'(y3) - DIFF_W'(y4);
        n_p_x1y2 = x1 * y2;
        n_p_y1x2 = y1 * x2;
        n_p_x3y4 = x3 * y4;
        n_p_y3x4 = y3 * x4;
    end

    // stage 2 logic
    always_comb begin
        n_c12 = CROSS_W'(r_p_x1y2) - CROSS_W'(r_p_y1x2);
        n_c34 = CROSS_W'(r_p_x3y4) - CROSS_W'(r_p_y3x4);
        n_da  = r_dx12 * r_dy34;
        n_db  = r_dy12 * r_dx34;
    end

    // stage 3 logic
    always_comb begin
        n_den3 = DEN_W'(r_da) - DEN_W'(r_db);
        n_na   = r_c12 * r2_dx34;
        n_nb   = r2_dx12 * r_c34;
        n_nc   = r_c12 * r2_dy34;
        n_nd   = r2_dy12 * r_c34;
    end

    // stage 4 logic
    always_comb begin
        n_nx = NUM_W'(r_na) - NUM_W'(r_nb);
        n_ny = NUM_W'(r_nc) - NUM_W'(r_nd);
    end

    // stage 5 logic: magnitudes, quotient signs, divisor at top alignment
    always_comb begin
        mag_x = r_nx[NUM_W-1] ? NUM_W'(-r_nx) : NUM_W'(r_nx);
        mag_y = r_ny[NUM_W-1] ? NUM_W'(-r_ny) : NUM_W'(r_ny);
        mag_d = r_den4[DEN_W-1] ? DEN_W'(-r_den4) : DEN_W'(r_den4);
        n_div          = '0;
        n_div.parallel = (r_den4 == '0);
        n_div.neg_x    = r_nx[NUM_W-1] ^ r_den4[DEN_W-1];
        n_div.neg_y    = r_ny[NUM_W-1] ^ r_den4[DEN_W-1];
        n_div.divisor  = {mag_d, {(QUOT_W-1){1'b0}}};
        n_div.rem_x    = mag_x;
        n_div.rem_y    = mag_y;
        n_div.coords   = r_c4;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx12   <= n_dx12;
            r_dy12   <= n_dy12;
            r_dx34   <= n_dx34;
            r_dy34   <= n_dy34;
            r_p_x1y2 <= n_p_x1y2;
            r_p_y1x2 <= n_p_y1x2;
            r_p_x3y4 <= n_p_x3y4;
            r_p_y3x4 <= n_p_y3x4;
            r_c1     <= i_coords;

            r_c12    <= n_c12;
            r_c34    <= n_c34;
            r_da     <= n_da;
            r_db     <= n_db;
            r2_dx12  <= r_dx12;
            r2_dy12  <= r_dy12;
            r2_dx34  <= r_dx34;
            r2_dy34  <= r_dy34;
            r_c2     <= r_c1;

            r_den3   <= n_den3;
            r_na     <= n_na;
            r_nb     <= n_nb;
            r_nc     <= n_nc;
            r_nd     <= n_nd;
            r_c3     <= r_c2;

            r_den4   <= r_den3;
            r_nx     <= n_nx;
            r_ny     <= n_ny;
            r_c4     <= r_c3;

            r_div    <= n_div;
        end
    end

    assign o_valid = r_valid[4];
    assign o_div   = r_div;

endmodule

FILE: rtl/sip_div_stage.sv
// ----------------------------------------------------------------------------
// sip_div_stage
// One restoring division step for both coordinates: compare and subtract
// the aligned divisor, shift in one quotient bit, register the result.
// ----------------------------------------------------------------------------
module sip_div_stage import sip_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_div,
    output logic o_valid,
    output t_div o_div
);

    logic   r_valid;
    t_div   r_div;
    t_div   n_div;
    logic [SHDIV_W:0] ext_rx, ext_ry, ext_d;
    logic             ge_x, ge_y;

    // compare and subtract step
    always_comb begin
        ext_rx = (SHDIV_W + 1)'(i_div.rem_x);
        ext_ry = (SHDIV_W + 1)'(i_div.rem_y);
        ext_d  = {1'b0, i_div.divisor};
        ge_x   = (ext_rx >= ext_d);
        ge_y   = (ext_ry >= ext_d);
        n_div         = i_div;
        n_div.rem_x   = ge_x ? NUM_W'(ext_rx - ext_d) : i_div.rem_x;
        n_div.rem_y   = ge_y ? NUM_W'(ext_ry - ext_d) : i_div.rem_y;
        n_div.quot_x  = {i_div.quot_x[QUOT_W-2:0], ge_x};
        n_div.quot_y  = {i_div.quot_y[QUOT_W-2:0], ge_y};
        n_div.divisor = {1'b0, i_div.divisor[SHDIV_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

FILE: rtl/sip_back.sv
// ----------------------------------------------------------------------------
// sip_back
// Signs and saturates the quotients, runs the inclusive bound test and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module sip_back import sip_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  t_div                         i_div,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic                         o_parallel,
    output logic signed [COORD_BITS-1:0] o_cross_x,
    output logic signed [COORD_BITS-1:0] o_cross_y
);

    logic                         r_valid;
    logic                         r_hit, r_parallel;
    logic signed [COORD_BITS-1:0] r_cross_x, r_cross_y;

    logic                         n_hit;
    logic signed [COORD_BITS-1:0] n_cross_x, n_cross_y, px, py;

    // signed saturation of a quotient magnitude
    function automatic logic signed [COORD_BITS-1:0] sat_quot(
        input logic              neg,
        input logic [QUOT_W-1:0] q
    );
        logic signed [COORD_BITS-1:0] res;
        if (neg) begin
            res = (q > QMAX_NEG) ? COORD_MIN : COORD_BITS'(-q);
        end else begin
            res = (q > QMAX_POS) ? COORD_MAX : COORD_BITS'(q);
        end
        return res;
    endfunction

    // inclusive range test between two endpoints in either order
    function automatic logic in_span(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b,
        input logic signed [COORD_BITS-1:0] c
    );
        logic lo_ok, hi_ok;
        lo_ok = (c >= a) || (c >= b);
        hi_ok = (c <= a) || (c <= b);
        return lo_ok && hi_ok && ((c >= a && c <= b) || (c >= b && c <= a));
    endfunction

    // result selection
    always_comb begin
        px = sat_quot(i_div.neg_x, i_div.quot_x);
        py = sat_quot(i_div.neg_y, i_div.quot_y);
        n_hit = in_span(i_div.coords[IDX_X1], i_div.coords[IDX_X2], px)
             && in_span(i_div.coords[IDX_Y1], i_div.coords[IDX_Y2], py)
             && in_span(i_div.coords[IDX_X3], i_div.coords[IDX_X4], px)
             && in_span(i_div.coords[IDX_Y3], i_div.coords[IDX_Y4], py);
        n_cross_x = px;
        n_cross_y = py;
        if (i_div.parallel) begin
            n_hit     = 1'b0;
            n_cross_x = '0;
            n_cross_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit      <= n_hit;
            r_parallel <= i_div.parallel;
            r_cross_x  <= n_cross_x;
            r_cross_y  <= n_cross_y;
        end
    end

    assign o_valid    = r_valid;
    assign o_hit      = r_hit;
    assign o_parallel = r_parallel;
    assign o_cross_x  = r_cross_x;
    assign o_cross_y  = r_cross_y;

endmodule

FILE: rtl/segment_intersection_point.sv
// ----------------------------------------------------------------------------
// segment_intersection_point
// Intersection point of two line segments in signed Q11.4, streamed.
// ----------------------------------------------------------------------------
// Takes one segment pair per cycle while not stalled and returns one
// result per pair, in order: five stages form the exact determinant
// denominator and numerators, 18 restoring division stages (one
// quotient bit each, the top one detecting overflow) produce the
// truncated point, and a final stage saturates, runs the inclusive bound
// test and holds the output. The whole pipeline advances together; it
// stalls only while a result waits at the output with m_axis_tready low.
module segment_intersection_point import sip_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit, parallel, cross_x, cross_y, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                         en;
    logic [QUOT_W:0]              stg_valid;
    t_div                         stg_div [QUOT_W+1];
    logic                         hit, parallel;
    logic signed [COORD_BITS-1:0] cross_x, cross_y;

    // global advance: move unless the output holds an untaken result
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    sip_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid),
        .i_coords (t_coords'(s_axis_tdata)),
        .o_valid  (stg_valid[0]),
        .o_div    (stg_div[0])
    );

    // divider stages
    for (genvar g = 0; g < QUOT_W; g++) begin : g_div
        sip_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stg_valid[g]),
            .i_div   (stg_div[g]),
            .o_valid (stg_valid[g+1]),
            .o_div   (stg_div[g+1])
        );
    end

    sip_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (stg_valid[QUOT_W]),
        .i_div      (stg_div[QUOT_W]),
        .o_valid    (m_axis_tvalid),
        .o_hit      (hit),
        .o_parallel (parallel),
        .o_cross_x  (cross_x),
        .o_cross_y  (cross_y)
    );

    // output packing
    assign m_axis_tdata = OUT_DATA_W'({cross_y, cross_x, parallel, hit});

endmodule
